/* design/lzpd_pkg.sv */
// ----------------------------------------------------------------------------
// lzpd_pkg
// Shared types, constants and helpers for the LZ77 page decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzpd_pkg;

  // History window and derived address width.
  localparam int unsigned WINDOW_BYTES = 32768;
  localparam int unsigned HIST_AW      = $clog2(WINDOW_BYTES);

  // Field and counter widths.
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned DIST_W  = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd29696;

  // Opcode and length constants of the stream format.
  localparam logic [7:0] OP_LONG_A   = 8'h10;
  localparam logic [7:0] OP_END      = 8'h11;
  localparam logic [7:0] OP_LONG_B   = 8'h20;
  localparam logic [7:0] OP_SHORT    = 8'h40;
  localparam logic [7:0] OP_BIAS_B   = 8'h1E;
  localparam logic [7:0] LITLEN_MAX  = 8'h0F;
  localparam logic [7:0] EXT_STEP    = 8'hFF;
  localparam logic [DIST_W-1:0] FAR_BIAS = 16'h3FFF;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Reported status.
  typedef enum logic [1:0] {
    ST_NEED  = 2'd0,
    ST_PEND  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ERROR = 2'd3
  } status_e;

  // Parser phase, one-hot.
  typedef enum logic [11:0] {
    PH_START     = 12'b0000_0000_0001,
    PH_LITLEN    = 12'b0000_0000_0010,
    PH_LITEXT    = 12'b0000_0000_0100,
    PH_LIT       = 12'b0000_0000_1000,
    PH_OPCODE    = 12'b0000_0001_0000,
    PH_LONGLEN   = 12'b0000_0010_0000,
    PH_OFS1      = 12'b0000_0100_0000,
    PH_OFS2      = 12'b0000_1000_0000,
    PH_OFS_SHORT = 12'b0001_0000_0000,
    PH_MATCH     = 12'b0010_0000_0000,
    PH_DONE      = 12'b0100_0000_0000,
    PH_ERROR     = 12'b1000_0000_0000
  } phase_e;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
    logic       in_last;
  } lzpd_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;
  } lzpd_out_t;

  // Work handed from the parser to the emit stage for one accepted item.
  typedef struct packed {
    logic               from_mem;
    logic               zero;
    logic               wr;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_AW-1:0] rd_addr;
    logic [7:0]         lit;
    logic               out_valid;
    logic [1:0]         status;
  } lzpd_req_t;

  // Saturating add on a 24-bit length count.
  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [8:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W-8){1'b0}}, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/lz77_page_decompressor.sv */
// ----------------------------------------------------------------------------
// lz77_page_decompressor
// Byte-stream LZ77 page decoder with a 32 KiB history memory.
// ----------------------------------------------------------------------------
//  channel  signals                           direction  payload
//  input    in_valid_i / in_ready_o           in         lzpd_in_t
//  output   out_valid_o / out_ready_i         out        lzpd_out_t
//  config   cfg_we_i                          in         cfg_data_i (limit)
//
// One transaction is accepted per cycle while the output side keeps up.
// The history memory is read at the accepting edge; at the next edge the
// byte is written back and the result enters the output buffer.
// in_ready_o drops only while the two-entry output buffer would stay full
// after this cycle, that is, with two results the receiver has not taken.
// Reset clears control state only; history needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77_page_decompressor (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lzpd_pkg::LIMIT_W-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire lzpd_pkg::lzpd_in_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output lzpd_pkg::lzpd_out_t               out_data_o
);
  import lzpd_pkg::*;

  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  logic               wr_en;
  logic [HIST_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               req_valid;
  lzpd_req_t          req;

  // Parser and page state.
  lzpd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .rd_addr_o   (rd_addr),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // History memory.
  lzpd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Emit stage and output buffer.
  lzpd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* design/lzpd_ram.sv */
// ----------------------------------------------------------------------------
// lzpd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

/* design/lzpd_parse.sv */
// ----------------------------------------------------------------------------
// lzpd_parse
// Stream parser: holds the page state, decodes each accepted transaction and
// issues the history read and the work for the emit stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lzpd_parse (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lzpd_pkg::LIMIT_W-1:0]      cfg_data_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_i,
  input  wire lzpd_pkg::lzpd_in_t                in_data_i,
  output logic      [lzpd_pkg::HIST_AW-1:0]      rd_addr_o,
  output logic                                   req_valid_o,
  output lzpd_pkg::lzpd_req_t                    req_o
);
  import lzpd_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  phase_e             phase_q, phase_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [7:0]         opcode_q, opcode_d;
  logic [7:0]         ofs1_q, ofs1_d;
  logic [LEN_W-1:0]   mrem_q, mrem_d;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic [LEN_W-1:0]   lrem_q, lrem_d;

  logic               accept;
  logic [7:0]         b;
  phase_e             op_phase;
  logic [LEN_W-1:0]   op_mrem;
  logic [COUNT_W-1:0] limit_ext;
  logic [COUNT_W-1:0] room;
  logic [LEN_W-1:0]   mrem_clip;
  logic [DIST_W-1:0]  off_long;
  logic [DIST_W-1:0]  off_short;
  logic [HIST_AW-1:0] rd_addr;
  phase_e             after_phase;

  assign accept      = in_valid_i && in_ready_i;
  assign b           = in_data_i.in_byte;
  assign req_valid_o = accept;

  // Opcode decode: next phase and initial match length.
  always_comb begin
    op_phase = PH_ERROR;
    op_mrem  = mrem_q;
    if (b == OP_END) begin
      op_phase = PH_DONE;
    end else if (b < OP_LONG_A) begin
      op_phase = PH_ERROR;
    end else if (b == OP_LONG_A) begin
      op_phase = PH_LONGLEN;
      op_mrem  = 24'd9;
    end else if (b < OP_LONG_B) begin
      op_phase = PH_OFS1;
      op_mrem  = {20'd0, b[3:0]} + 24'd2;
    end else if (b == OP_LONG_B) begin
      op_phase = PH_LONGLEN;
      op_mrem  = 24'h21;
    end else if (b < OP_SHORT) begin
      op_phase = PH_OFS1;
      op_mrem  = {16'd0, b} - {16'd0, OP_BIAS_B};
    end else begin
      op_phase = PH_OFS_SHORT;
      op_mrem  = {20'd0, b[7:4]} - 24'd1;
    end
  end

  // Room left under the limit, match clipping and offsets.
  assign limit_ext = {1'b0, limit_q};
  assign room      = (limit_ext > count_q) ? (limit_ext - count_q) : '0;
  assign mrem_clip = (mrem_q > {{(LEN_W-COUNT_W){1'b0}}, room})
                   ? {{(LEN_W-COUNT_W){1'b0}}, room} : mrem_q;
  assign off_long  = {2'b00, b, ofs1_q[7:2]}
                   + ((opcode_q < OP_LONG_B) ? FAR_BIAS : '0);
  assign off_short = {6'd0, b, opcode_q[3:2]};
  assign rd_addr   = count_q[HIST_AW-1:0] - dist_q[HIST_AW-1:0];
  assign after_phase = (lrem_q != '0) ? PH_LIT : PH_LITLEN;
  assign rd_addr_o = rd_addr;

  // Next page state and the work for the emit stage.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    opcode_d = opcode_q;
    ofs1_d   = ofs1_q;
    mrem_d   = mrem_q;
    dist_d   = dist_q;
    lrem_d   = lrem_q;
    req_o           = '0;
    req_o.wr_addr   = count_q[HIST_AW-1:0];
    req_o.rd_addr   = rd_addr;
    if (accept) begin
      case (in_data_i.command)
        CMD_START: begin
          phase_d  = PH_START;
          count_d  = '0;
          opcode_d = '0;
          ofs1_d   = '0;
          mrem_d   = '0;
          dist_d   = '0;
          lrem_d   = '0;
        end
        CMD_FEED: begin
          if (phase_q == PH_MATCH || phase_q == PH_DONE || phase_q == PH_ERROR) begin
            // Byte is dropped.
          end else if (phase_q == PH_START && in_data_i.in_last) begin
            phase_d = PH_ERROR;
          end else begin
            unique case (phase_q)
              PH_START, PH_LITLEN: begin
                if (b > LITLEN_MAX) begin
                  lrem_d   = '0;
                  opcode_d = b;
                  phase_d  = op_phase;
                  mrem_d   = op_mrem;
                end else if (b == 8'd0) begin
                  lrem_d  = {16'd0, LITLEN_MAX};
                  phase_d = PH_LITEXT;
                end else begin
                  lrem_d  = {16'd0, b} + 24'd3;
                  phase_d = PH_LIT;
                end
              end
              PH_LITEXT: begin
                if (b == 8'd0) begin
                  lrem_d = sat_add(lrem_q, {1'b0, EXT_STEP});
                end else begin
                  lrem_d  = sat_add(lrem_q, {1'b0, b} + 9'd3);
                  phase_d = PH_LIT;
                end
              end
              PH_LIT: begin
                lrem_d = lrem_q - 24'd1;
                if (lrem_q == 24'd1) begin
                  phase_d = PH_OPCODE;
                end
                if (count_q < limit_ext) begin
                  req_o.wr        = 1'b1;
                  req_o.lit       = b;
                  req_o.out_valid = 1'b1;
                  count_d         = count_q + 21'd1;
                end
              end
              PH_OPCODE: begin
                opcode_d = b;
                phase_d  = op_phase;
                mrem_d   = op_mrem;
              end
              PH_LONGLEN: begin
                if (b == 8'd0) begin
                  mrem_d = sat_add(mrem_q, {1'b0, EXT_STEP});
                end else begin
                  mrem_d  = sat_add(mrem_q, {1'b0, b});
                  phase_d = PH_OFS1;
                end
              end
              PH_OFS1: begin
                ofs1_d  = b;
                phase_d = PH_OFS2;
              end
              PH_OFS2, PH_OFS_SHORT: begin
                // Start a back-reference, clipped to the room left.
                if (phase_q == PH_OFS2) begin
                  dist_d = off_long + 16'd1;
                  lrem_d = {22'd0, ofs1_q[1:0]};
                end else begin
                  dist_d = off_short + 16'd1;
                  lrem_d = {22'd0, opcode_q[1:0]};
                end
                mrem_d = mrem_clip;
                if (mrem_clip != '0) begin
                  phase_d = PH_MATCH;
                end else if (lrem_d != '0) begin
                  phase_d = PH_LIT;
                end else begin
                  phase_d = PH_LITLEN;
                end
              end
              default: begin
              end
            endcase
            // A last byte other than the end opcode is an error.
            if (in_data_i.in_last && phase_d != PH_DONE) begin
              phase_d         = PH_ERROR;
              req_o.out_valid = 1'b0;
              req_o.lit       = '0;
            end
          end
        end
        CMD_PULL: begin
          if (phase_q == PH_MATCH) begin
            req_o.from_mem  = 1'b1;
            req_o.zero      = {{(COUNT_W-DIST_W){1'b0}}, dist_q} > count_q;
            req_o.wr        = 1'b1;
            req_o.out_valid = 1'b1;
            count_d         = count_q + 21'd1;
            mrem_d          = mrem_q - 24'd1;
            if (mrem_q == 24'd1) begin
              phase_d = after_phase;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // Status after the step.
    if (phase_d == PH_DONE) begin
      req_o.status = ST_DONE;
    end else if (phase_d == PH_ERROR) begin
      req_o.status = ST_ERROR;
    end else if (phase_d == PH_MATCH) begin
      req_o.status = ST_PEND;
    end else begin
      req_o.status = ST_NEED;
    end
  end

  // Output limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Page state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      count_q  <= '0;
      opcode_q <= '0;
      ofs1_q   <= '0;
      mrem_q   <= '0;
      dist_q   <= '0;
      lrem_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      opcode_q <= opcode_d;
      ofs1_q   <= ofs1_d;
      mrem_q   <= mrem_d;
      dist_q   <= dist_d;
      lrem_q   <= lrem_d;
    end
  end

  // A pending match always has bytes left and a nonzero distance.
  a_match_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MATCH) |-> (mrem_q != '0 && dist_q != '0))
    else $error("match pending with no length or distance");

  // Starting a page clears the output count.
  a_start_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.command == CMD_START) |=> (count_q == '0 && phase_q == PH_START))
    else $error("page start did not clear the state");

endmodule

`default_nettype wire

/* design/lzpd_emit.sv */
// ----------------------------------------------------------------------------
// lzpd_emit
// Emit stage: takes the history read data, forwards a same-cycle write,
// writes the produced byte back and queues the result in a two-entry buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module lzpd_emit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            req_valid_i,
  input  wire lzpd_pkg::lzpd_req_t             req_i,
  input  wire logic [7:0]                      rd_data_i,
  output logic                                 wr_en_o,
  output logic      [lzpd_pkg::HIST_AW-1:0]    wr_addr_o,
  output logic      [7:0]                      wr_data_o,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lzpd_pkg::lzpd_out_t                  out_data_o
);
  import lzpd_pkg::*;

  logic               s1_vld_q;
  lzpd_req_t          s1_q;
  logic               fwd_vld_q;
  logic [HIST_AW-1:0] fwd_addr_q;
  logic [7:0]         fwd_data_q;
  lzpd_out_t          buf_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;

  logic               fwd_hit;
  logic [7:0]         mem_byte;
  logic [7:0]         byte_val;
  lzpd_out_t          result;
  logic               push, pop;

  // Byte selection, with bypass of the write that landed with our read.
  assign fwd_hit  = fwd_vld_q && (fwd_addr_q == s1_q.rd_addr);
  assign mem_byte = fwd_hit ? fwd_data_q : rd_data_i;
  assign byte_val = s1_q.from_mem ? (s1_q.zero ? 8'd0 : mem_byte) : s1_q.lit;

  assign wr_en_o   = s1_vld_q && s1_q.wr;
  assign wr_addr_o = s1_q.wr_addr;
  assign wr_data_o = byte_val;

  assign result.out_byte  = s1_q.out_valid ? byte_val : 8'd0;
  assign result.out_valid = s1_q.out_valid;
  assign result.status    = s1_q.status;

  // Output buffer handshake. A new transaction is taken only if the buffer
  // keeps a free slot after this cycle, so its result can always be pushed.
  assign push        = s1_vld_q;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = buf_q[rd_ptr_q];
  assign in_ready_o  = (cnt_d < 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Stage and buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      cnt_q     <= '0;
    end else begin
      s1_vld_q  <= req_valid_i;
      fwd_vld_q <= wr_en_o;
      cnt_q     <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Stage and buffer payload.
  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      s1_q <= req_i;
    end
    fwd_addr_q <= wr_addr_o;
    fwd_data_q <= wr_data_o;
    if (push) begin
      buf_q[wr_ptr_q] <= result;
    end
  end

  // The buffer never holds more than two results.
  a_cnt_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output buffer overfilled");

  // A result in the stage always finds a free buffer slot.
  a_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (cnt_q < 2'd2 || pop))
    else $error("result arrived with no buffer room");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for lz77_page_decompressor
// Drives command transactions from a queue, predicts every output
// transaction with a bit-accurate decoder, and checks the outputs in order.
// Pages are mostly well formed with random content, plus noise and broken
// pages, across several output limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lzpd_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_CYCLES     = 200;
  localparam int HOLD_AFTER      = 150;
  localparam int MAX_PRINTS      = 50;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX    = '1;
  localparam logic [LEN_W-1:0]   LONG_A_LEN = 24'd9;
  localparam logic [LEN_W-1:0]   LONG_B_LEN = 24'h21;

  // Clock, reset and DUT-facing signals.
  logic               clk;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  lzpd_in_t           in_data  = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lzpd_out_t          out_data;

  // Pending command transactions and predicted output transactions.
  lzpd_in_t  cmd_q[$];
  lzpd_out_t decoded_q[$];

  bit        calm = 1'b0;
  bit        in_took = 1'b0;
  int        err_count = 0;
  int        rx_seen = 0;
  int        idle_cycles = 0;
  int        made = 0;
  int        gen_limit;
  int        gen_out;
  lzpd_out_t want;
  lzpd_out_t got;

  // Decoder state mirrored by the predictor.
  logic [LIMIT_W-1:0] lim_m;
  logic [7:0]         hist_m [WINDOW_BYTES];
  logic [COUNT_W-1:0] cnt_m;
  phase_e             ph_m;
  logic [7:0]         op_m;
  logic [7:0]         ofs_m;
  logic [LEN_W-1:0]   mlen_m;
  logic [LEN_W-1:0]   llen_m;
  logic [DIST_W-1:0]  dist_m;

  lz77_page_decompressor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Clock generation, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Length counts saturate at 24 bits instead of wrapping.
  function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a,
                                               input logic [8:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {16'b0, b};
    return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
  endfunction

  task automatic clear_page();
    cnt_m  = '0;
    ph_m   = PH_START;
    op_m   = '0;
    ofs_m  = '0;
    mlen_m = '0;
    dist_m = '0;
    llen_m = '0;
  endtask

  // After a match, trailing literals come first, else a literal-length byte.
  task automatic resume_parse();
    if (llen_m != 0) begin
      ph_m = PH_LIT;
    end else begin
      ph_m = PH_LITLEN;
    end
  endtask

  // A match is clipped to the room left under the output limit.
  task automatic arm_match(input logic [16:0] off);
    logic [COUNT_W-1:0] room;
    room   = (COUNT_W'(lim_m) > cnt_m) ? COUNT_W'(lim_m) - cnt_m : '0;
    dist_m = DIST_W'(off + 17'd1);
    if (mlen_m > LEN_W'(room)) begin
      mlen_m = LEN_W'(room);
    end
    if (mlen_m != 0) begin
      ph_m = PH_MATCH;
    end else begin
      resume_parse();
    end
  endtask

  task automatic load_opcode(input logic [7:0] b);
    op_m = b;
    if (b == OP_END) begin
      ph_m = PH_DONE;
    end else if (b < OP_LONG_A) begin
      ph_m = PH_ERROR;
    end else if (b == OP_LONG_A) begin
      mlen_m = LONG_A_LEN;
      ph_m   = PH_LONGLEN;
    end else if (b < OP_LONG_B) begin
      mlen_m = LEN_W'(b & 8'h0F) + 24'd2;
      ph_m   = PH_OFS1;
    end else if (b == OP_LONG_B) begin
      mlen_m = LONG_B_LEN;
      ph_m   = PH_LONGLEN;
    end else if (b < OP_SHORT) begin
      mlen_m = LEN_W'(b - OP_BIAS_B);
      ph_m   = PH_OFS1;
    end else begin
      mlen_m = LEN_W'(b >> 4) - 24'd1;
      ph_m   = PH_OFS_SHORT;
    end
  endtask

  // Predict the output transaction caused by one command transaction.
  task automatic decode_item(input lzpd_in_t it, output lzpd_out_t r);
    logic [7:0]         b;
    logic [7:0]         obyte;
    logic               vld;
    logic [16:0]        off;
    logic [COUNT_W-1:0] src;
    b     = it.in_byte;
    obyte = '0;
    vld   = 1'b0;
    case (it.command)
      CMD_START: begin
        clear_page();
      end
      CMD_FEED: begin
        if (ph_m == PH_MATCH || ph_m == PH_DONE || ph_m == PH_ERROR) begin
          // The byte is dropped while a match is pending or the page has ended.
        end else if (ph_m == PH_START && it.in_last) begin
          ph_m = PH_ERROR;
        end else begin
          case (ph_m)
            PH_START, PH_LITLEN: begin
              if (b > LITLEN_MAX) begin
                llen_m = '0;
                load_opcode(b);
              end else if (b == 8'h00) begin
                llen_m = LEN_W'(LITLEN_MAX);
                ph_m   = PH_LITEXT;
              end else begin
                llen_m = LEN_W'(b) + 24'd3;
                ph_m   = PH_LIT;
              end
            end
            PH_LITEXT: begin
              if (b == 8'h00) begin
                llen_m = len_add(llen_m, 9'(EXT_STEP));
              end else begin
                llen_m = len_add(llen_m, 9'(b) + 9'd3);
                ph_m   = PH_LIT;
              end
            end
            PH_LIT: begin
              llen_m = llen_m - 24'd1;
              if (llen_m == 0) begin
                ph_m = PH_OPCODE;
              end
              if (COUNT_W'(lim_m) > cnt_m) begin
                hist_m[cnt_m[HIST_AW-1:0]] = b;
                cnt_m = cnt_m + 1'b1;
                obyte = b;
                vld   = 1'b1;
              end
            end
            PH_OPCODE: begin
              load_opcode(b);
            end
            PH_LONGLEN: begin
              if (b == 8'h00) begin
                mlen_m = len_add(mlen_m, 9'(EXT_STEP));
              end else begin
                mlen_m = len_add(mlen_m, 9'(b));
                ph_m   = PH_OFS1;
              end
            end
            PH_OFS1: begin
              ofs_m = b;
              ph_m  = PH_OFS2;
            end
            PH_OFS2: begin
              off = 17'(ofs_m >> 2) | (17'(b) << 6);
              if (op_m < OP_LONG_B) begin
                off = off + 17'(FAR_BIAS);
              end
              llen_m = LEN_W'(ofs_m & 8'h03);
              arm_match(off);
            end
            PH_OFS_SHORT: begin
              off    = (17'(b) << 2) | 17'((op_m & 8'h0C) >> 2);
              llen_m = LEN_W'(op_m & 8'h03);
              arm_match(off);
            end
            default: begin
            end
          endcase
          // A final byte that does not end the page is a premature end.
          if (it.in_last && ph_m != PH_DONE) begin
            ph_m  = PH_ERROR;
            vld   = 1'b0;
            obyte = '0;
          end
        end
      end
      CMD_PULL: begin
        if (ph_m == PH_MATCH) begin
          src   = cnt_m - COUNT_W'(dist_m);
          obyte = (COUNT_W'(dist_m) <= cnt_m) ? hist_m[src[HIST_AW-1:0]] : 8'h00;
          hist_m[cnt_m[HIST_AW-1:0]] = obyte;
          cnt_m  = cnt_m + 1'b1;
          vld    = 1'b1;
          mlen_m = mlen_m - 24'd1;
          if (mlen_m == 0) begin
            resume_parse();
          end
        end
      end
      default: begin
      end
    endcase
    r.out_byte  = obyte;
    r.out_valid = vld;
    if (ph_m == PH_DONE) begin
      r.status = ST_DONE;
    end else if (ph_m == PH_ERROR) begin
      r.status = ST_ERROR;
    end else if (ph_m == PH_MATCH) begin
      r.status = ST_PEND;
    end else begin
      r.status = ST_NEED;
    end
  endtask

  // Print one mismatch line (up to a cap) and count it.
  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    if (err_count < MAX_PRINTS) begin
      $display("Mismatch on output %0d: %s got 0x%0h, expected 0x%0h",
               rx_seen, what, got_v, want_v);
    end
    err_count++;
  endtask

  // Driver: offer the next command transaction at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99, 0) >= 33)) begin
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the block.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99, 0) >= 33);
      end
    end
  end

  // Monitor: predict on input transactions, check output transactions.
  always @(posedge clk) begin
    if (rst_n) begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        decode_item(in_data, want);
        decoded_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (decoded_q.size() == 0) begin
          report_mismatch("output with nothing expected", got.out_byte, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", got.out_byte, want.out_byte);
          end
          if (got.out_valid !== want.out_valid) begin
            report_mismatch("out_valid", 8'(got.out_valid), 8'(want.out_valid));
          end
          if (got.status !== want.status) begin
            report_mismatch("status", 8'(got.status), 8'(want.status));
          end
        end
        rx_seen++;
      end
      // Watchdog on cycles without any accepted transaction.
      if (in_took || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic queue_item(input cmd_e c, input logic [7:0] b, input logic l);
    lzpd_in_t it;
    it.command = c;
    it.in_byte = b;
    it.in_last = l;
    cmd_q.push_back(it);
    made++;
  endtask

  task automatic feed(input logic [7:0] b, input logic l = 1'b0);
    queue_item(CMD_FEED, b, l);
  endtask

  task automatic pull();
    queue_item(CMD_PULL, 8'($urandom), 1'($urandom));
  endtask

  task automatic new_page();
    queue_item(CMD_START, 8'($urandom), 1'($urandom));
  endtask

  // Wait until every queued transaction has been accepted and answered.
  task automatic wait_drain();
    while (cmd_q.size() != 0 || in_valid || decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input int v);
    wait_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= LIMIT_W'(v);
    lim_m     = LIMIT_W'(v);
    gen_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One literal byte; the generator tracks how many bytes the page produced.
  task automatic emit_literal();
    feed(8'($urandom));
    if (gen_out < gen_limit) begin
      gen_out++;
    end
  endtask

  // Pulls for a match, with ignored feeds mixed in while it is pending.
  task automatic play_match(input int len);
    int room;
    int eff;
    room = (gen_limit > gen_out) ? gen_limit - gen_out : 0;
    eff  = (len < room) ? len : room;
    for (int k = 0; k < eff; k++) begin
      pull();
      if (k < eff - 1 && $urandom_range(11, 0) == 0) begin
        feed(8'($urandom), 1'($urandom));
      end
    end
    gen_out += eff;
  endtask

  // Extended length bytes after opcode 0x10 or 0x20.
  task automatic long_len(inout int len);
    int b;
    if ($urandom_range(19, 0) == 0) begin
      feed(8'h00);
      len += 255;
    end
    b = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 1) : $urandom_range(8, 1);
    feed(8'(b));
    len += b;
  endtask

  // Harmless noise between instructions: no-op commands and idle pulls.
  task automatic noise();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) begin
      queue_item(CMD_NONE, 8'($urandom), 1'($urandom));
    end else if (r == 1) begin
      pull();
    end
  endtask

  // A well-formed page with random content and a randomly chosen ending.
  // No new instruction starts once the item count reaches stop_at.
  task automatic gen_page(input int n_ins, input int stop_at);
    bit can_litlen;
    int op;
    int len;
    int lits;
    int o1;
    int o2;
    int cnt;
    int b;
    int e;
    new_page();
    gen_out    = 0;
    can_litlen = 1'b1;
    for (int i = 0; i < n_ins && made < stop_at; i++) begin
      noise();
      if (can_litlen && $urandom_range(1, 0) == 1) begin
        if ($urandom_range(9, 0) == 0) begin
          feed(8'h00);
          cnt = 15;
          if ($urandom_range(3, 0) == 0) begin
            feed(8'h00);
            cnt += 255;
          end
          b = $urandom_range(12, 1);
          feed(8'(b));
          cnt += b + 3;
        end else begin
          b = $urandom_range(15, 1);
          feed(8'(b));
          cnt = b + 3;
        end
        repeat (cnt) emit_literal();
      end
      case ($urandom_range(4, 0))
        0: begin
          op  = OP_LONG_A;
          len = LONG_A_LEN;
          feed(8'(op));
          long_len(len);
        end
        1: begin
          op  = $urandom_range(8'h1F, 8'h12);
          len = (op & 8'h0F) + 2;
          feed(8'(op));
        end
        2: begin
          op  = OP_LONG_B;
          len = LONG_B_LEN;
          feed(8'(op));
          long_len(len);
        end
        3: begin
          op  = $urandom_range(8'h3F, 8'h21);
          len = op - OP_BIAS_B;
          feed(8'(op));
        end
        default: begin
          op  = $urandom_range(8'hFF, OP_SHORT);
          len = (op >> 4) - 1;
          feed(8'(op));
        end
      endcase
      if (op < OP_SHORT) begin
        o1 = $urandom_range(255, 0);
        o2 = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0) : 0;
        feed(8'(o1));
        feed(8'(o2));
        lits = o1 & 3;
      end else begin
        o1 = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(15, 0);
        feed(8'(o1));
        lits = op & 3;
      end
      play_match(len);
      repeat (lits) emit_literal();
      can_litlen = (lits == 0);
    end
    e = $urandom_range(19, 0);
    if (e < 15) begin
      feed(OP_END, 1'b1);
    end else if (e == 15) begin
      // Ended without the last flag; the following feed is ignored.
      feed(OP_END);
      feed(8'($urandom), 1'($urandom));
    end else if (e < 18) begin
      feed(8'($urandom_range(15, 0)), 1'($urandom));
    end else begin
      feed(8'($urandom), 1'b1);
    end
  endtask

  // A broken page: random commands and bytes.
  task automatic gen_junk();
    int c;
    new_page();
    repeat ($urandom_range(15, 3)) begin
      c = $urandom_range(7, 0);
      if (c == 0) begin
        pull();
      end else if (c == 1) begin
        queue_item(CMD_NONE, 8'($urandom), 1'($urandom));
      end else begin
        feed(8'($urandom), $urandom_range(7, 0) == 0);
      end
    end
  endtask

  task automatic run_random(input int limit_val, input bit quiet, input int n);
    int first;
    set_limit(limit_val);
    calm  = quiet;
    first = made;
    while (made - first < n) begin
      if ($urandom_range(99, 0) < 15) begin
        gen_junk();
      end else begin
        gen_page($urandom_range(6, 0), first + n);
      end
    end
    wait_drain();
    calm = 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    lim_m     = LIMIT_RESET;
    gen_limit = LIMIT_RESET;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      hist_m[i] = 8'h00;
    end
    clear_page();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: literals at the byte extremes, a short match, errors.
    new_page();
    feed(8'h03);
    feed(8'h00);
    feed(8'hFF);
    feed(8'hA5);
    feed(8'h5A);
    feed(8'h01);
    feed(8'h80);
    feed(8'h41);
    feed(8'h00);
    pull();
    pull();
    pull();
    feed(8'h7E);
    feed(8'h0F);
    feed(8'h33, 1'b1);
    new_page();
    feed(8'h05, 1'b1);
    new_page();
    feed(8'h01);
    feed(8'hAA, 1'b1);
    new_page();
    feed(OP_END, 1'b1);
    pull();

    // Limit lowered below the produced count in the middle of a page.
    new_page();
    feed(8'h01);
    repeat (4) feed(8'($urandom));
    set_limit(2);
    feed(8'h13);
    feed(8'h04);
    feed(8'h00);
    pull();
    feed(OP_END, 1'b1);

    // Random pages across several output limits.
    run_random(LIMIT_RESET, 1'b0, 180);
    run_random(0, 1'b0, 50);
    run_random($urandom_range(40, 1), 1'b1, 100);
    run_random(LIMIT_MAX, 1'b0, 120);
    run_random($urandom_range(LIMIT_MAX, 0), 1'b0, 80);

    // Final drain and verdict.
    wait_drain();
    repeat (20) @(posedge clk);
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
